### src/iphpc_pkg.sv
package iphpc_pkg;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_VERSION = 2'd1;
    localparam logic [1:0] ST_CHECKSUM    = 2'd2;
    localparam logic [1:0] ST_SHORT_IHL   = 2'd3;

    localparam int unsigned RES_W    = 158;
    localparam int unsigned M_DATA_W = 160;

    // first member sits in the top bits, so status lands at bit 0
    typedef struct packed {
        logic [15:0] payload_len;
        logic [31:0] dest_addr;
        logic [31:0] source_addr;
        logic [7:0]  protocol;
        logic [7:0]  time_to_live;
        logic [12:0] fragment_offset;
        logic [2:0]  flag_bits;
        logic [15:0] ident;
        logic [15:0] total_length;
        logic [7:0]  service_type;
        logic [3:0]  header_words;
        logic [1:0]  status;
    } res_t;

endpackage

### src/iphpc_core.sv
module iphpc_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic [15:0]      frame_len,
    input  logic [3:0]       expected_version,
    output logic             res_valid,
    output iphpc_pkg::res_t  res
);
    import iphpc_pkg::*;

    // byte positions within the header (version/IHL byte is position 0)
    localparam logic [5:0] K_TOS      = 6'd1;
    localparam logic [5:0] K_LEN_HI   = 6'd2;
    localparam logic [5:0] K_LEN_LO   = 6'd3;
    localparam logic [5:0] K_ID_HI    = 6'd4;
    localparam logic [5:0] K_ID_LO    = 6'd5;
    localparam logic [5:0] K_FF_HI    = 6'd6;
    localparam logic [5:0] K_FF_LO    = 6'd7;
    localparam logic [5:0] K_TTL      = 6'd8;
    localparam logic [5:0] K_PROTO    = 6'd9;
    localparam logic [5:0] K_CSUM_HI  = 6'd10;
    localparam logic [5:0] K_CSUM_LO  = 6'd11;
    localparam logic [5:0] K_SRC_0    = 6'd12;
    localparam logic [5:0] K_SRC_1    = 6'd13;
    localparam logic [5:0] K_SRC_2    = 6'd14;
    localparam logic [5:0] K_SRC_3    = 6'd15;
    localparam logic [5:0] K_DST_0    = 6'd16;
    localparam logic [5:0] K_DST_1    = 6'd17;
    localparam logic [5:0] K_DST_2    = 6'd18;
    localparam logic [5:0] K_DST_3    = 6'd19;
    localparam logic [3:0] IHL_MIN    = 4'd5;

    logic        in_header_reg, in_header_next;
    logic [5:0]  byte_count_reg, byte_count_next;
    logic [20:0] sum_reg, sum_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] given_csum_reg, given_csum_next;
    logic [7:0]  tos_reg, tos_next;
    logic [15:0] total_len_reg, total_len_next;
    logic [15:0] ident_reg, ident_next;
    logic [15:0] ff_reg, ff_next;
    logic [7:0]  ttl_reg, ttl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] dst_reg, dst_next;

    logic [1:0]  status;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] csum_calc;
    logic [15:0] hdr_bytes;

    // end-around carry fold of the running sum; two passes cover 21 bits
    always_comb begin
        fold1     = {1'b0, sum_next[15:0]} + {12'b0, sum_next[20:16]};
        fold2     = fold1[15:0] + {15'b0, fold1[16]};
        csum_calc = ~fold2;
    end

    always_comb begin
        in_header_next  = in_header_reg;
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        high_byte_next  = high_byte_reg;
        frame_len_next  = frame_len_reg;
        ihl_next        = ihl_reg;
        given_csum_next = given_csum_reg;
        tos_next        = tos_reg;
        total_len_next  = total_len_reg;
        ident_next      = ident_reg;
        ff_next         = ff_reg;
        ttl_next        = ttl_reg;
        proto_next      = proto_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        res_valid       = 1'b0;
        status          = ST_OK;

        if (accept && first_byte) begin
            frame_len_next  = frame_len;
            ihl_next        = data_byte[3:0];
            given_csum_next = '0;
            sum_next        = '0;
            high_byte_next  = data_byte;
            byte_count_next = 6'd1;
            in_header_next  = 1'b0;
            tos_next        = '0;
            total_len_next  = '0;
            ident_next      = '0;
            ff_next         = '0;
            ttl_next        = '0;
            proto_next      = '0;
            src_next        = '0;
            dst_next        = '0;
            if (data_byte[7:4] != expected_version) begin
                res_valid = 1'b1;
                status    = ST_BAD_VERSION;
            end else if (data_byte[3:0] < IHL_MIN) begin
                res_valid = 1'b1;
                status    = ST_SHORT_IHL;
            end else begin
                in_header_next = 1'b1;
            end
        end else if (accept && in_header_reg) begin
            case (byte_count_reg)
                K_TOS:     tos_next              = data_byte;
                K_LEN_HI:  total_len_next[15:8]  = data_byte;
                K_LEN_LO:  total_len_next[7:0]   = data_byte;
                K_ID_HI:   ident_next[15:8]      = data_byte;
                K_ID_LO:   ident_next[7:0]       = data_byte;
                K_FF_HI:   ff_next[15:8]         = data_byte;
                K_FF_LO:   ff_next[7:0]          = data_byte;
                K_TTL:     ttl_next              = data_byte;
                K_PROTO:   proto_next            = data_byte;
                K_CSUM_HI: given_csum_next[15:8] = data_byte;
                K_CSUM_LO: given_csum_next[7:0]  = data_byte;
                K_SRC_0:   src_next[31:24]       = data_byte;
                K_SRC_1:   src_next[23:16]       = data_byte;
                K_SRC_2:   src_next[15:8]        = data_byte;
                K_SRC_3:   src_next[7:0]         = data_byte;
                K_DST_0:   dst_next[31:24]       = data_byte;
                K_DST_1:   dst_next[23:16]       = data_byte;
                K_DST_2:   dst_next[15:8]        = data_byte;
                K_DST_3:   dst_next[7:0]         = data_byte;
                default:   ;
            endcase

            // odd positions close a 16-bit word; the checksum word is skipped
            if (byte_count_reg[0]) begin
                if (byte_count_reg != K_CSUM_LO) begin
                    sum_next = sum_reg + {5'b0, high_byte_reg, data_byte};
                end
            end else begin
                high_byte_next = data_byte;
            end

            if (({1'b0, byte_count_reg} + 7'd1) >= {1'b0, ihl_reg, 2'b00}) begin
                in_header_next  = 1'b0;
                byte_count_next = '0;
                res_valid       = 1'b1;
                status          = (csum_calc == given_csum_next) ? ST_OK : ST_CHECKSUM;
            end else begin
                byte_count_next = byte_count_reg + 6'd1;
            end
        end
    end

    always_comb begin
        hdr_bytes           = {10'b0, ihl_next, 2'b00};
        res.status          = status;
        res.header_words    = ihl_next;
        res.service_type    = tos_next;
        res.total_length    = total_len_next;
        res.ident           = ident_next;
        res.flag_bits       = ff_next[15:13];
        res.fragment_offset = ff_next[12:0];
        res.time_to_live    = ttl_next;
        res.protocol        = proto_next;
        res.source_addr     = src_next;
        res.dest_addr       = dst_next;
        res.payload_len     = (frame_len_next > hdr_bytes) ? (frame_len_next - hdr_bytes)
                                                           : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_header_reg  <= 1'b0;
            byte_count_reg <= '0;
        end else begin
            in_header_reg  <= in_header_next;
            byte_count_reg <= byte_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg        <= sum_next;
        high_byte_reg  <= high_byte_next;
        frame_len_reg  <= frame_len_next;
        ihl_reg        <= ihl_next;
        given_csum_reg <= given_csum_next;
        tos_reg        <= tos_next;
        total_len_reg  <= total_len_next;
        ident_reg      <= ident_next;
        ff_reg         <= ff_next;
        ttl_reg        <= ttl_next;
        proto_reg      <= proto_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
    end

endmodule

### src/ipv4_header_parse_check.sv
// IPv4 header parser with header checksum check. Packet bytes come in one per
// transaction on the s_ channel, the first byte flagged on s_tuser together with
// the frame length. Each byte is absorbed when accepted (field capture plus
// one 16-bit word add into the running sum), so the block sustains one byte per
// clock while s_tready is high; the carry fold and checksum compare sit in the
// same pass as the last header byte. At most one result per packet leaves on
// m_tdata, registered, once the last header byte (IHL*4 bytes) or a first byte
// that already fails the version or IHL check is taken. A skid stage behind the
// output register keeps s_tready high until two results are waiting downstream.
// Bytes after the header are dropped until the next first byte.
module ipv4_header_parse_check (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // data_byte[7:0], frame_len[23:8]
    input  logic         s_tuser,   // first_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // status[1:0], header_words[5:2], service_type[13:6],
                                    // total_length[29:14], ident[45:30], flag_bits[48:46],
                                    // fragment_offset[61:49], time_to_live[69:62],
                                    // protocol[77:70], source_addr[109:78],
                                    // dest_addr[141:110], payload_len[157:142], zero pad
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data   // expected_version
);
    import iphpc_pkg::*;

    localparam logic [3:0] VERSION_RESET = 4'd4;

    logic [3:0] exp_version_reg;
    logic       accept;
    logic       res_valid;
    res_t       res;
    logic       out_valid_reg;
    res_t       out_reg;
    logic       skid_valid_reg;
    res_t       skid_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(M_DATA_W - RES_W){1'b0}}, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_version_reg <= VERSION_RESET;
        end else if (cfg_valid && cfg_ready) begin
            exp_version_reg <= cfg_data;
        end
    end

    iphpc_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .data_byte        (s_tdata[7:0]),
        .first_byte       (s_tuser),
        .frame_len        (s_tdata[23:8]),
        .expected_version (exp_version_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    // output register with skid; a new result can only arrive while skid is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= res_valid;
            end
        end else if (res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (res_valid) begin
            skid_reg <= res;
        end
    end

endmodule

### src/iphpc_checker.sv
module iphpc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [23:0]  s_tdata,
    input logic         s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [3:0]   cfg_data
);
    import iphpc_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result payload changed while stalled");

    // input only backs off when both output stages are occupied
    a_ready_low_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // early errors report no header fields beyond IHL and payload length
    a_early_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == ST_BAD_VERSION || m_tdata[1:0] == ST_SHORT_IHL)
        |-> m_tdata[141:6] == '0)
        else $error("early error result carries header fields");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind ipv4_header_parse_check iphpc_checker u_iphpc_checker (.*);

### verif/tb_ipv4_header_parse_check.sv
`timescale 1ns / 100ps

module tb_ipv4_header_parse_check;
    import iphpc_pkg::*;

    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN_CYC = 8;
    localparam int PHASE_BYTES = 250;
    localparam int N_PHASES = 8;
    localparam logic [3:0] PHASE_VER [N_PHASES] = '{4'd4, 4'd0, 4'd15, 4'd4,
                                                     4'd9, 4'd15, 4'd0, 4'd4};

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic [15:0] flen;
    } stim_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic [15:0] flen;
        logic        typed;
        logic [1:0]  st;
        logic [15:0] pay;
    } dir_row_t;

    typedef enum int {PK_GOOD, PK_BADSUM, PK_BADVER, PK_SHORTIHL, PK_CUT, PK_JUNK} pkt_kind_t;

    localparam int DIR_N = 28;
    // typed rows: first-byte errors, expected fields readable by eye
    localparam dir_row_t DIR_TAB [DIR_N] = '{
        '{8'h45, 1'b1, 16'h0073, 1'b0, ST_OK, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        // new packet in the middle of a header, bad version
        '{8'h00, 1'b1, 16'h0000, 1'b1, ST_BAD_VERSION, 16'h0000},
        '{8'h11, 1'b0, 16'hffff, 1'b0, ST_OK, 16'h0000},
        '{8'hff, 1'b1, 16'hffff, 1'b1, ST_BAD_VERSION, 16'hffc3},
        '{8'h43, 1'b1, 16'h000a, 1'b1, ST_SHORT_IHL, 16'h0000},
        '{8'h40, 1'b1, 16'hffff, 1'b1, ST_SHORT_IHL, 16'hffff},
        // valid 20-byte header, frame shorter than the header
        '{8'h45, 1'b1, 16'h0008, 1'b0, ST_OK, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h73, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h40, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h40, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h11, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'hb8, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h61, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'hc0, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'ha8, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h01, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'hc0, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'ha8, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'h00, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        '{8'hc7, 1'b0, 16'h0000, 1'b0, ST_OK, 16'h0000},
        // byte after the header, dropped
        '{8'ha5, 1'b0, 16'h1234, 1'b0, ST_OK, 16'h0000}
    };

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [23:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_data;

    ipv4_header_parse_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // parser model state
    logic [3:0]  ver_cfg;
    logic        in_hdr;
    logic [5:0]  byte_idx;
    logic [20:0] word_sum;
    logic [7:0]  hi_byte;
    logic [15:0] cur_flen;
    logic [3:0]  cur_ihl;
    logic [15:0] chk_given;
    logic [7:0]  tos, ttl, proto;
    logic [15:0] tot_len, ident_w, frag_word;
    logic [63:0] addr_pair;

    res_t  exp_hdr_q [$];
    stim_t tx_q [$];

    int err_cnt = 0;
    int cyc = 0;
    int bytes_sent = 0;
    int hdrs_checked = 0;
    int cfg_writes = 0;
    int st_cnt [4] = '{0, 0, 0, 0};
    int snd_pct = 0;
    int rcv_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cyc++;
        if (cyc > CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cyc, exp_hdr_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic log_error(input string msg);
        err_cnt++;
        if (err_cnt <= 50)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_error($sformatf("%s: got %0h, expected %0h", name, got, want));
    endtask

    function automatic res_t hdr_result(input logic [1:0] st);
        res_t r;
        int   hl;
        hl = int'(cur_ihl) * 4;
        r = '0;
        r.status          = st;
        r.header_words    = cur_ihl;
        r.service_type    = tos;
        r.total_length    = tot_len;
        r.ident           = ident_w;
        r.flag_bits       = frag_word[15:13];
        r.fragment_offset = frag_word[12:0];
        r.time_to_live    = ttl;
        r.protocol        = proto;
        r.source_addr     = addr_pair[63:32];
        r.dest_addr       = addr_pair[31:0];
        r.payload_len     = (int'(cur_flen) > hl) ? 16'(int'(cur_flen) - hl) : 16'h0;
        return r;
    endfunction

    // one byte into the parser model; returns 1 when a header result is produced
    function automatic bit parse_byte(input logic [7:0] b, input logic first,
                                      input logic [15:0] flen, output res_t r);
        int          k;
        logic [21:0] s;
        r = '0;
        if (first) begin
            tos = '0; ttl = '0; proto = '0;
            tot_len = '0; ident_w = '0; frag_word = '0; addr_pair = '0;
            cur_flen  = flen;
            cur_ihl   = b[3:0];
            chk_given = '0;
            word_sum  = '0;
            hi_byte   = b;
            byte_idx  = 6'd1;
            in_hdr    = 1'b0;
            if (b[7:4] != ver_cfg) begin
                r = hdr_result(ST_BAD_VERSION);
                return 1'b1;
            end
            if (cur_ihl < 4'd5) begin
                r = hdr_result(ST_SHORT_IHL);
                return 1'b1;
            end
            in_hdr = 1'b1;
            return 1'b0;
        end
        if (!in_hdr)
            return 1'b0;

        k = int'(byte_idx);
        case (k)
            1:  tos = b;
            2:  tot_len[15:8] = b;
            3:  tot_len[7:0] = b;
            4:  ident_w[15:8] = b;
            5:  ident_w[7:0] = b;
            6:  frag_word[15:8] = b;
            7:  frag_word[7:0] = b;
            8:  ttl = b;
            9:  proto = b;
            10: chk_given = {b, 8'h00};
            11: chk_given[7:0] = b;
            default: begin
                if (k >= 12 && k <= 19)
                    addr_pair[(19 - k) * 8 +: 8] = b;
            end
        endcase

        // odd index closes a 16-bit word; the checksum word stays out of the sum
        if (k % 2 == 1) begin
            if (k != 11)
                word_sum = word_sum + {5'b0, hi_byte, b};
        end else begin
            hi_byte = b;
        end

        if (k + 1 >= int'(cur_ihl) * 4) begin
            s = {1'b0, word_sum};
            s = {6'b0, s[15:0]} + {16'b0, s[21:16]};
            s = {6'b0, s[15:0]} + {16'b0, s[21:16]};
            in_hdr   = 1'b0;
            byte_idx = '0;
            r = hdr_result((~s[15:0] == chk_given) ? ST_OK : ST_CHECKSUM);
            return 1'b1;
        end
        byte_idx = 6'(k + 1);
        return 1'b0;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input stim_t it, input bit typed, input res_t typed_res);
        res_t pr;
        bit   got;
        while (snd_pct != 0 && $urandom_range(0, 99) < snd_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.flen, it.data};
        s_tuser  <= it.first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = parse_byte(it.data, it.first, it.flen, pr);
        if (typed)
            exp_hdr_q.push_back(typed_res);
        else if (got)
            exp_hdr_q.push_back(pr);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (exp_hdr_q.size() != 0) @(posedge aclk);
        // partial headers or dropped bytes may still be in flight
        repeat (DRAIN_CYC) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_version(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        ver_cfg = v;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // queue up one packet: mostly well-formed headers with random content
    task automatic make_packet();
        logic [7:0]  hb [60];
        logic [21:0] acc;
        logic [15:0] fl;
        logic [3:0]  v;
        int          roll, ihl, n, i, tail;
        pkt_kind_t   kind;
        stim_t       it;

        roll = $urandom_range(0, 99);
        if (roll < 55)      kind = PK_GOOD;
        else if (roll < 70) kind = PK_BADSUM;
        else if (roll < 78) kind = PK_BADVER;
        else if (roll < 85) kind = PK_SHORTIHL;
        else if (roll < 93) kind = PK_CUT;
        else                kind = PK_JUNK;

        ihl = ($urandom_range(0, 9) < 7) ? 5 : $urandom_range(6, 15);
        n = ihl * 4;
        for (i = 0; i < 60; i++)
            hb[i] = 8'($urandom);
        hb[0] = {ver_cfg, 4'(ihl)};

        acc = '0;
        for (i = 0; i < n; i += 2) begin
            if (i != 10)
                acc = acc + {6'b0, hb[i], hb[i + 1]};
        end
        acc = {6'b0, acc[15:0]} + {16'b0, acc[21:16]};
        acc = {6'b0, acc[15:0]} + {16'b0, acc[21:16]};
        hb[10] = ~acc[15:8];
        hb[11] = ~acc[7:0];

        case (kind)
            PK_BADSUM: begin
                i = $urandom_range(1, n - 1);
                hb[i] = hb[i] ^ (8'h01 << $urandom_range(0, 7));
            end
            PK_BADVER: begin
                do v = 4'($urandom); while (v == ver_cfg);
                hb[0][7:4] = v;
                n = 1;
            end
            PK_SHORTIHL: begin
                hb[0][3:0] = 4'($urandom_range(0, 4));
                n = 1;
            end
            PK_CUT:  n = $urandom_range(1, n - 1);
            PK_JUNK: n = 0;
            default: ;
        endcase

        case ($urandom_range(0, 3))
            0, 1:    fl = 16'(ihl * 4 + $urandom_range(0, 40));
            2:       fl = 16'($urandom);
            default: fl = 16'($urandom_range(0, ihl * 4));
        endcase

        for (i = 0; i < n; i++) begin
            it.data  = hb[i];
            it.first = (i == 0);
            it.flen  = (i == 0) ? fl : 16'($urandom);
            tx_q.push_back(it);
        end

        if (kind == PK_JUNK || (kind != PK_CUT && $urandom_range(0, 3) == 0)) begin
            tail = $urandom_range(1, 4);
            for (i = 0; i < tail; i++) begin
                it.data  = 8'($urandom);
                it.first = 1'b0;
                it.flen  = 16'($urandom);
                tx_q.push_back(it);
            end
        end
    endtask

    always @(negedge aclk)
        m_tready <= (rcv_pct == 0) || ($urandom_range(0, 99) >= rcv_pct);

    always @(posedge aclk) begin
        res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[RES_W-1:0]);
            st_cnt[got.status]++;
            if (exp_hdr_q.size() == 0) begin
                log_error($sformatf("result with nothing expected, status %0d", got.status));
            end else begin
                want = exp_hdr_q.pop_front();
                hdrs_checked++;
                check_field("status", 32'(got.status), 32'(want.status));
                check_field("header_words", 32'(got.header_words), 32'(want.header_words));
                check_field("service_type", 32'(got.service_type), 32'(want.service_type));
                check_field("total_length", 32'(got.total_length), 32'(want.total_length));
                check_field("ident", 32'(got.ident), 32'(want.ident));
                check_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
                check_field("fragment_offset", 32'(got.fragment_offset),
                            32'(want.fragment_offset));
                check_field("time_to_live", 32'(got.time_to_live), 32'(want.time_to_live));
                check_field("protocol", 32'(got.protocol), 32'(want.protocol));
                check_field("source_addr", got.source_addr, want.source_addr);
                check_field("dest_addr", got.dest_addr, want.dest_addr);
                check_field("payload_len", 32'(got.payload_len), 32'(want.payload_len));
            end
        end
    end

    initial begin
        res_t     tr;
        stim_t    it;
        dir_row_t row;
        int       ph, sent, pause_at, i;
        bit       paused;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        m_tready  = 1'b1;
        ver_cfg   = 4'd4;
        in_hdr    = 1'b0;
        byte_idx  = '0;
        word_sum  = '0;
        hi_byte   = '0;
        cur_flen  = '0;
        cur_ihl   = '0;
        chk_given = '0;
        tos = '0; ttl = '0; proto = '0;
        tot_len = '0; ident_w = '0; frag_word = '0; addr_pair = '0;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // directed pass at the reset version setting
        for (i = 0; i < DIR_N; i++) begin
            row = DIR_TAB[i];
            it.data  = row.data;
            it.first = row.first;
            it.flen  = row.flen;
            tr = '0;
            tr.status       = row.st;
            tr.header_words = row.data[3:0];
            tr.payload_len  = row.pay;
            send_byte(it, row.typed, tr);
        end

        // random phases: version setting and idle pattern change between them
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            write_version(PHASE_VER[ph]);
            case (ph % 4)
                0:       begin snd_pct = 0;  rcv_pct = 0;  end
                1:       begin snd_pct = 67; rcv_pct = 0;  end
                2:       begin snd_pct = 0;  rcv_pct = 67; end
                default: begin snd_pct = 11; rcv_pct = 11; end
            endcase
            sent = 0;
            pause_at = $urandom_range(50, 200);
            paused = 1'b0;
            // finish the packet in progress so the block is idle at the next write
            while (sent < PHASE_BYTES || tx_q.size() != 0) begin
                if (tx_q.size() == 0)
                    make_packet();
                if (!paused && sent >= pause_at) begin
                    drain_results();
                    paused = 1'b1;
                end
                send_byte(tx_q.pop_front(), 1'b0, '0);
                sent++;
            end
        end

        drain_results();
        $display("%0d bytes in, %0d headers checked, %0d version writes, %0d errors",
                 bytes_sent, hdrs_checked, cfg_writes, err_cnt);
        $display("results seen: ok %0d, bad version %0d, checksum %0d, short ihl %0d",
                 st_cnt[ST_OK], st_cnt[ST_BAD_VERSION], st_cnt[ST_CHECKSUM],
                 st_cnt[ST_SHORT_IHL]);
        if (err_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### ipv4_header_parse_check.f
src/iphpc_pkg.sv
src/iphpc_core.sv
src/ipv4_header_parse_check.sv
src/iphpc_checker.sv
verif/tb_ipv4_header_parse_check.sv
